/* hw/rtl/pca_pkg.sv */
// ----------------------------------------------------------------------------
// Phone confusion alignment package
// Shared types and constants for the aligner controller and datapath.
// ----------------------------------------------------------------------------
package pca_pkg;

	localparam logic [1:0] ACT_PUSH_REF = 2'd0;
	localparam logic [1:0] ACT_PUSH_OBS = 2'd1;
	localparam logic [1:0] ACT_ALIGN    = 2'd2;
	localparam logic [1:0] ACT_READ     = 2'd3;

	localparam logic [1:0] TR_MAT = 2'd0;
	localparam logic [1:0] TR_DEL = 2'd1;
	localparam logic [1:0] TR_INS = 2'd2;
	localparam logic [1:0] TR_SUB = 2'd3;

	localparam int PHONE_W = 6;
	localparam int SUBS_W  = 6;
	localparam int THR_W   = 16;
	localparam int OUT_CNT_W = 16;
	localparam logic [15:0] THRESHOLD_RESET = 16'd10;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic push_ref;
		logic push_obs;
		logic clr_step;     // write one confusion entry to zero
		logic init_step;    // write one border cell
		logic fill_rd;      // issue reads for the current inner cell
		logic fill_wr;      // compute and write the current inner cell
		logic bt_rd;        // read trace at the current backtrace point
		logic bt_step;      // consume the trace and move
		logic acc_rd;       // read count for a pending substitution
		logic acc_wr;       // write incremented count back
		logic read_rd;      // read count for a read item
		logic start_align;  // latch lengths and reset counters
		logic end_align;    // clear lengths
	} pca_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_done;
		logic init_done;
		logic fill_done;
		logic bt_done;
		logic acc_pending;
		logic empty;
	} pca_sts_t;

endpackage

/* hw/rtl/phone_confusion_alignment.sv */
// ----------------------------------------------------------------------------
// Phone confusion alignment
// Edit-distance aligner of two phone sequences with a confusion count matrix.
// ----------------------------------------------------------------------------
// Items arrive on the s_ channel; every item yields one result on the m_
// channel. A push result shows the cycle after the push is accepted. A read
// passes through ST_READ, as the count memory read is registered, before its
// result is captured. An align runs border init (cell (k,0) then (0,k) for
// each index up to max(n,m)), fill (table read, then compute and write, per
// cell), backtrace (trace read, then step, per path step) and, for each
// counted substitution, a count update (sequence read, count read, write back).
// One item is in work at a time; s_tready stays low while a result waits,
// so a stalled receiver holds the block. After reset the count memory is
// cleared one entry a cycle, all NUM_PHONES*NUM_PHONES entries (4096 by
// default), before the first item is accepted. The threshold register is
// written on cfg_valid/cfg_ready and may be written at any time.
// ----------------------------------------------------------------------------
module phone_confusion_alignment #(
	parameter int MAX_LEN    = 32,
	parameter int NUM_PHONES = 64,
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // action[1:0], phone[7:2], row[13:8], col[19:14]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // count[15:0], above_threshold[16], substitutions[22:17],
	                               // status[23]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	pca_pkg::pca_cmd_t cmd;
	pca_pkg::pca_sts_t sts;
	logic cap_push, cap_read, cap_align, push_full, rd_above;
	logic [15:0] rd_count;
	logic [5:0] subs;
	logic [15:0] thr_q;
	logic [23:0] res_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= pca_pkg::THRESHOLD_RESET;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	pca_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.action(s_tdata[1:0]), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.cap_push(cap_push), .cap_read(cap_read), .cap_align(cap_align),
		.cmd(cmd), .sts(sts));

	pca_datapath #(.MAX_LEN(MAX_LEN), .NUM_PHONES(NUM_PHONES), .COUNT_BITS(COUNT_BITS))
	u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.phone(s_tdata[7:2]), .row(s_tdata[13:8]), .col(s_tdata[19:14]),
		.threshold(thr_q), .push_full(push_full), .rd_count(rd_count),
		.rd_above(rd_above), .subs(subs));

	always_ff @(posedge clk) begin
		if (cap_push) res_q <= {push_full, 23'd0};
		else if (cap_read) res_q <= {7'd0, rd_above, rd_count};
		else if (cap_align) res_q <= {1'b0, subs, 17'd0};
	end

	assign m_tdata = res_q;

endmodule

/* hw/rtl/pca_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hw/rtl/pca_datapath.sv */
// ----------------------------------------------------------------------------
// Phone confusion alignment datapath
// Sequence stores, cost and trace tables, backtrace and confusion counts.
// ----------------------------------------------------------------------------
module pca_datapath #(
	parameter int MAX_LEN    = 32,
	parameter int NUM_PHONES = 64,
	parameter int COUNT_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pca_pkg::pca_cmd_t              cmd,
	output pca_pkg::pca_sts_t              sts,
	input  logic [pca_pkg::PHONE_W-1:0]    phone,
	input  logic [pca_pkg::PHONE_W-1:0]    row,
	input  logic [pca_pkg::PHONE_W-1:0]    col,
	input  logic [pca_pkg::THR_W-1:0]      threshold,
	output logic                           push_full,
	output logic [pca_pkg::OUT_CNT_W-1:0]  rd_count,
	output logic                           rd_above,
	output logic [pca_pkg::SUBS_W-1:0]     subs
);

	localparam int LEN_W = $clog2(MAX_LEN + 1);
	localparam int SEQ_AW = $clog2(MAX_LEN);
	localparam int DIM = MAX_LEN + 1;
	localparam int TAB_D = DIM * DIM;
	localparam int TAB_AW = $clog2(TAB_D);
	localparam int COST_W = $clog2(2 * MAX_LEN + 1);
	localparam int CNT_D = NUM_PHONES * NUM_PHONES;
	localparam int CNT_AW = $clog2(CNT_D);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	logic [LEN_W-1:0] ref_len_q, obs_len_q, n_q, m_q, i_q, j_q;
	logic [TAB_AW-1:0] base_q;  // i_q * DIM, kept incrementally
	logic [CNT_AW:0] clr_q;

	// Sequence RAMs: write on push, read during fill and accumulate.
	logic [SEQ_AW-1:0] ref_ra, obs_ra;
	logic [pca_pkg::PHONE_W-1:0] ref_rd, obs_rd;
	logic ref_full, obs_full;
	assign ref_full = (ref_len_q == LEN_W'(MAX_LEN));
	assign obs_full = (obs_len_q == LEN_W'(MAX_LEN));
	assign push_full = (cmd.push_ref && ref_full) || (cmd.push_obs && obs_full);

	pca_ram #(.WIDTH(pca_pkg::PHONE_W), .DEPTH(MAX_LEN)) u_ref (
		.clk(clk), .we(cmd.push_ref && !ref_full), .waddr(ref_len_q[SEQ_AW-1:0]),
		.wdata(phone), .raddr(ref_ra), .rdata(ref_rd));
	pca_ram #(.WIDTH(pca_pkg::PHONE_W), .DEPTH(MAX_LEN)) u_obs (
		.clk(clk), .we(cmd.push_obs && !obs_full), .waddr(obs_len_q[SEQ_AW-1:0]),
		.wdata(phone), .raddr(obs_ra), .rdata(obs_rd));

	// Cost table: three reads per cell are served by three copies.
	logic cost_we, tr_we;
	logic [TAB_AW-1:0] cost_wa, tr_wa, up_a, left_a, diag_a, tr_ra;
	logic [COST_W-1:0] cost_wd, up_c, left_c, diag_c;
	logic [1:0] tr_wd, tr_rd;

	pca_ram #(.WIDTH(COST_W), .DEPTH(TAB_D)) u_cost_up (
		.clk(clk), .we(cost_we), .waddr(cost_wa), .wdata(cost_wd),
		.raddr(up_a), .rdata(up_c));
	pca_ram #(.WIDTH(COST_W), .DEPTH(TAB_D)) u_cost_left (
		.clk(clk), .we(cost_we), .waddr(cost_wa), .wdata(cost_wd),
		.raddr(left_a), .rdata(left_c));
	pca_ram #(.WIDTH(COST_W), .DEPTH(TAB_D)) u_cost_diag (
		.clk(clk), .we(cost_we), .waddr(cost_wa), .wdata(cost_wd),
		.raddr(diag_a), .rdata(diag_c));
	pca_ram #(.WIDTH(2), .DEPTH(TAB_D)) u_trace (
		.clk(clk), .we(tr_we), .waddr(tr_wa), .wdata(tr_wd),
		.raddr(tr_ra), .rdata(tr_rd));

	// Border init walks k = 0..max(n,m): cell (k,0) then (0,k) for each k.
	logic init_ph_q;
	logic [LEN_W-1:0] k_q;
	logic [TAB_AW-1:0] kbase_q;
	logic [LEN_W-1:0] init_max;
	assign init_max = (n_q > m_q) ? n_q : m_q;

	logic cur_match;
	assign cur_match = (ref_rd == obs_rd);
	logic [COST_W-1:0] cell_cost;
	logic [1:0] cell_tr;
	always_comb begin
		if (cur_match) begin
			cell_cost = diag_c;
			cell_tr = pca_pkg::TR_MAT;
		end else if (up_c < left_c && up_c < diag_c) begin
			cell_cost = up_c + COST_W'(1);
			cell_tr = pca_pkg::TR_DEL;
		end else if (left_c < up_c && left_c < diag_c) begin
			cell_cost = left_c + COST_W'(1);
			cell_tr = pca_pkg::TR_INS;
		end else begin
			cell_cost = diag_c + COST_W'(1);
			cell_tr = pca_pkg::TR_SUB;
		end
	end

	logic [TAB_AW-1:0] cell_a;
	assign cell_a = base_q + TAB_AW'(j_q);

	always_comb begin
		cost_we = 1'b0;
		tr_we = 1'b0;
		cost_wa = cell_a;
		tr_wa = cell_a;
		cost_wd = cell_cost;
		tr_wd = cell_tr;
		if (cmd.init_step) begin
			cost_we = 1'b1;
			tr_we = 1'b1;
			if (!init_ph_q) begin
				cost_wa = kbase_q;
				tr_wd = pca_pkg::TR_DEL;
			end else begin
				cost_wa = TAB_AW'(k_q);
				tr_wd = pca_pkg::TR_INS;
			end
			tr_wa = cost_wa;
			cost_wd = COST_W'(k_q);
		end else if (cmd.fill_wr) begin
			cost_we = 1'b1;
			tr_we = 1'b1;
		end
	end

	assign up_a = cell_a - TAB_AW'(DIM);
	assign left_a = cell_a - TAB_AW'(1);
	assign diag_a = cell_a - TAB_AW'(DIM + 1);
	assign tr_ra = cell_a;

	// Backtrace window of three codes: later, current, and then earlier.
	logic have_cur_q, have_later_q;
	logic [1:0] later_q, cur_q;
	logic [SEQ_AW-1:0] cur_ri_q, cur_oi_q;
	logic acc_pend_q;
	logic [SEQ_AW-1:0] acc_ri_q, acc_oi_q;
	logic [pca_pkg::SUBS_W-1:0] subs_q;
	logic bt_end;
	assign bt_end = (i_q == '0) || (j_q == '0);

	// A substitution is isolated when its later and earlier neighbors are matches.
	logic cand_eval, cand_hit;
	logic [1:0] earlier_code;
	always_comb begin
		cand_eval = 1'b0;
		earlier_code = pca_pkg::TR_MAT;
		if (cmd.bt_step && have_cur_q) begin
			cand_eval = 1'b1;
			earlier_code = tr_rd;
		end else if (cmd.bt_rd && bt_end && have_cur_q) begin
			cand_eval = 1'b1;
		end
		cand_hit = cand_eval && cur_q == pca_pkg::TR_SUB &&
			(!have_later_q || later_q == pca_pkg::TR_MAT) &&
			earlier_code == pca_pkg::TR_MAT;
	end

	// Confusion count memory.
	logic [COUNT_BITS-1:0] cnt_rd;
	logic cnt_we;
	logic [CNT_AW-1:0] cnt_wa, cnt_ra, acc_idx_q;
	logic [COUNT_BITS-1:0] cnt_wd;
	logic acc_ok_q;
	logic acc_valid_s1;
	logic [pca_pkg::PHONE_W-1:0] r_ph, o_ph;
	assign r_ph = ref_rd;
	assign o_ph = obs_rd;

	always_comb begin
		cnt_we = 1'b0;
		cnt_wa = acc_idx_q;
		cnt_wd = (cnt_rd == COUNT_MAX) ? cnt_rd : cnt_rd + COUNT_BITS'(1);
		if (cmd.clr_step) begin
			cnt_we = 1'b1;
			cnt_wa = clr_q[CNT_AW-1:0];
			cnt_wd = '0;
		end else if (cmd.acc_wr && acc_ok_q) begin
			cnt_we = 1'b1;
		end
	end

	// Out-of-range phones are never counted or returned, so truncation of the address
	// terms only happens when the result is discarded.
	logic rd_ok;
	assign rd_ok = (32'(row) < NUM_PHONES) && (32'(col) < NUM_PHONES);
	always_comb begin
		if (cmd.read_rd) begin
			cnt_ra = CNT_AW'(row) * CNT_AW'(NUM_PHONES) + CNT_AW'(col);
		end else begin
			cnt_ra = CNT_AW'(r_ph) * CNT_AW'(NUM_PHONES) + CNT_AW'(o_ph);
		end
	end

	pca_ram #(.WIDTH(COUNT_BITS), .DEPTH(CNT_D)) u_counts (
		.clk(clk), .we(cnt_we), .waddr(cnt_wa), .wdata(cnt_wd),
		.raddr(cnt_ra), .rdata(cnt_rd));

	// Sequence read addresses.
	always_comb begin
		if (cmd.acc_rd || acc_valid_s1) begin
			ref_ra = acc_ri_q;
			obs_ra = acc_oi_q;
		end else begin
			ref_ra = SEQ_AW'(i_q - LEN_W'(1));
			obs_ra = SEQ_AW'(j_q - LEN_W'(1));
		end
	end

	logic rd_ok_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_len_q <= '0;
			obs_len_q <= '0;
			n_q <= '0;
			m_q <= '0;
			i_q <= '0;
			j_q <= '0;
			base_q <= '0;
			clr_q <= '0;
			init_ph_q <= 1'b0;
			k_q <= '0;
			kbase_q <= '0;
			have_cur_q <= 1'b0;
			have_later_q <= 1'b0;
			later_q <= pca_pkg::TR_MAT;
			cur_q <= pca_pkg::TR_MAT;
			cur_ri_q <= '0;
			cur_oi_q <= '0;
			acc_pend_q <= 1'b0;
			acc_ri_q <= '0;
			acc_oi_q <= '0;
			acc_idx_q <= '0;
			acc_valid_s1 <= 1'b0;
			acc_ok_q <= 1'b0;
			subs_q <= '0;
			rd_ok_s1 <= 1'b0;
		end else begin
			if (cmd.push_ref && !ref_full) ref_len_q <= ref_len_q + LEN_W'(1);
			if (cmd.push_obs && !obs_full) obs_len_q <= obs_len_q + LEN_W'(1);
			if (cmd.clr_step) clr_q <= clr_q + (CNT_AW+1)'(1);
			rd_ok_s1 <= rd_ok;
			if (cmd.start_align) begin
				n_q <= ref_len_q;
				m_q <= obs_len_q;
				k_q <= '0;
				kbase_q <= '0;
				init_ph_q <= 1'b0;
				i_q <= LEN_W'(1);
				j_q <= LEN_W'(1);
				base_q <= TAB_AW'(DIM);
				subs_q <= '0;
				have_cur_q <= 1'b0;
				have_later_q <= 1'b0;
			end
			if (cmd.init_step) begin
				init_ph_q <= !init_ph_q;
				if (init_ph_q) begin
					k_q <= k_q + LEN_W'(1);
					kbase_q <= kbase_q + TAB_AW'(DIM);
				end
			end
			if (cmd.fill_wr) begin
				if (j_q == m_q) begin
					if (i_q == n_q) begin
						// Fill is over: park at the corner for the backtrace.
						j_q <= m_q;
					end else begin
						j_q <= LEN_W'(1);
						i_q <= i_q + LEN_W'(1);
						base_q <= base_q + TAB_AW'(DIM);
					end
				end else begin
					j_q <= j_q + LEN_W'(1);
				end
			end
			if (cmd.bt_step) begin
				have_cur_q <= 1'b1;
				have_later_q <= have_cur_q;
				later_q <= cur_q;
				cur_q <= tr_rd;
				cur_ri_q <= SEQ_AW'(i_q - LEN_W'(1));
				cur_oi_q <= SEQ_AW'(j_q - LEN_W'(1));
				unique case (tr_rd)
					pca_pkg::TR_DEL: begin
						i_q <= i_q - LEN_W'(1);
						base_q <= base_q - TAB_AW'(DIM);
					end
					pca_pkg::TR_INS: j_q <= j_q - LEN_W'(1);
					default: begin
						i_q <= i_q - LEN_W'(1);
						j_q <= j_q - LEN_W'(1);
						base_q <= base_q - TAB_AW'(DIM);
					end
				endcase
			end
			if (cmd.bt_rd && bt_end) have_cur_q <= 1'b0;
			if (cand_hit) begin
				acc_pend_q <= 1'b1;
				acc_ri_q <= cur_ri_q;
				acc_oi_q <= cur_oi_q;
				if (subs_q != '1) subs_q <= subs_q + pca_pkg::SUBS_W'(1);
			end
			// acc_rd: sequence read; s1: count read; acc_wr: write back.
			acc_valid_s1 <= cmd.acc_rd;
			if (acc_valid_s1) begin
				acc_ok_q <= (32'(r_ph) < NUM_PHONES) && (32'(o_ph) < NUM_PHONES);
				acc_idx_q <= cnt_ra;
			end
			if (cmd.acc_wr) acc_pend_q <= 1'b0;
			if (cmd.end_align) begin
				ref_len_q <= '0;
				obs_len_q <= '0;
			end
		end
	end

	logic [COUNT_BITS-1:0] thr_ext;
	assign thr_ext = (COUNT_BITS >= pca_pkg::THR_W) ?
		COUNT_BITS'(threshold) : COUNT_BITS'(threshold);
	logic thr_big;
	assign thr_big = (COUNT_BITS < pca_pkg::THR_W) &&
		((32'(threshold) >> COUNT_BITS) != 32'd0);

	always_comb begin
		if (!rd_ok_s1) begin
			rd_count = '0;
			rd_above = 1'b0;
		end else begin
			rd_count = (32'(cnt_rd) > 32'hFFFF) ? '1 : pca_pkg::OUT_CNT_W'(cnt_rd);
			rd_above = !thr_big && (cnt_rd > thr_ext);
		end
	end

	assign subs = subs_q;

	assign sts.clr_done = (clr_q == (CNT_AW+1)'(CNT_D));
	assign sts.init_done = init_ph_q && (k_q == init_max);
	assign sts.fill_done = (i_q == n_q) && (j_q == m_q);
	assign sts.bt_done = bt_end;
	assign sts.acc_pending = acc_pend_q;
	assign sts.empty = (n_q == '0) || (m_q == '0);

endmodule

/* hw/rtl/pca_ctrl.sv */
// ----------------------------------------------------------------------------
// Phone confusion alignment controller
// Sequences clearing after reset, and per item the pushes, reads, table fill, backtrace and count updates.
// ----------------------------------------------------------------------------
module pca_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [1:0]        action,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic              cap_push,
	output logic              cap_read,
	output logic              cap_align,
	output pca_pkg::pca_cmd_t cmd,
	input  pca_pkg::pca_sts_t sts
);

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_READ  = 4'd2;
	localparam logic [3:0] ST_INIT  = 4'd3;
	localparam logic [3:0] ST_FRD   = 4'd4;
	localparam logic [3:0] ST_FWR   = 4'd5;
	localparam logic [3:0] ST_BRD   = 4'd6;
	localparam logic [3:0] ST_BST   = 4'd7;
	localparam logic [3:0] ST_ARD   = 4'd8;
	localparam logic [3:0] ST_ACR   = 4'd9;
	localparam logic [3:0] ST_AWR   = 4'd10;
	localparam logic [3:0] ST_DONE  = 4'd11;

	logic [3:0] state_q, state_d;
	logic out_v_q;
	logic acc_then_done_q;
	logic take;

	assign s_tready = (state_q == ST_IDLE) && !out_v_q;
	assign take = s_tvalid && s_tready;
	assign m_tvalid = out_v_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		cap_push = 1'b0;
		cap_read = 1'b0;
		cap_align = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clr_done) state_d = ST_IDLE;
				else cmd.clr_step = 1'b1;
			end
			ST_IDLE: begin
				if (take) begin
					case (action)
						pca_pkg::ACT_PUSH_REF: begin
							cmd.push_ref = 1'b1;
							cap_push = 1'b1;
						end
						pca_pkg::ACT_PUSH_OBS: begin
							cmd.push_obs = 1'b1;
							cap_push = 1'b1;
						end
						pca_pkg::ACT_ALIGN: begin
							cmd.start_align = 1'b1;
							state_d = ST_INIT;
						end
						default: begin
							cmd.read_rd = 1'b1;
							state_d = ST_READ;
						end
					endcase
				end
			end
			ST_READ: begin
				cap_read = 1'b1;
				state_d = ST_IDLE;
			end
			ST_INIT: begin
				cmd.init_step = 1'b1;
				if (sts.init_done) state_d = sts.empty ? ST_DONE : ST_FRD;
			end
			ST_FRD: begin
				cmd.fill_rd = 1'b1;
				state_d = ST_FWR;
			end
			ST_FWR: begin
				cmd.fill_wr = 1'b1;
				state_d = sts.fill_done ? ST_BRD : ST_FRD;
			end
			ST_BRD: begin
				cmd.bt_rd = 1'b1;
				if (sts.bt_done) state_d = ST_DONE;
				else state_d = ST_BST;
			end
			ST_BST: begin
				cmd.bt_step = 1'b1;
				state_d = ST_BRD;
			end
			ST_ARD: begin
				cmd.acc_rd = 1'b1;
				state_d = ST_ACR;
			end
			ST_ACR: state_d = ST_AWR;
			ST_AWR: begin
				cmd.acc_wr = 1'b1;
				state_d = acc_then_done_q ? ST_DONE : ST_BRD;
			end
			ST_DONE: begin
				cmd.end_align = 1'b1;
				cap_align = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		// A freshly found isolated substitution is written back before moving on.
		if (sts.acc_pending && (state_q == ST_BRD || state_q == ST_DONE)) begin
			cmd.bt_rd = 1'b0;
			cmd.end_align = 1'b0;
			cap_align = 1'b0;
			state_d = ST_ARD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			out_v_q <= 1'b0;
			acc_then_done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (sts.acc_pending && (state_q == ST_BRD || state_q == ST_DONE)) begin
				acc_then_done_q <= (state_q == ST_DONE);
			end
			if (cap_push || cap_read || cap_align) out_v_q <= 1'b1;
			else if (m_tready) out_v_q <= 1'b0;
		end
	end

endmodule

/* tb/sv/tb_phone_confusion_alignment.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Phone confusion alignment testbench
// Loads phone sequence pairs, aligns them and reads confusion counts through
// the item stream. Every result is checked against a predictor that carries
// its own edit-distance table, backtrace and confusion matrix.
// ----------------------------------------------------------------------------
module tb_phone_confusion_alignment;

	localparam int SEQ_MAX = 32;
	localparam int PHONES  = 64;
	localparam int EDGE    = SEQ_MAX + 1;
	localparam longint CYCLE_LIMIT = 64'd3000000;

	typedef struct packed {
		logic [5:0] col;
		logic [5:0] row;
		logic [5:0] phone;
		logic [1:0] action;
	} cmd_item_t;

	typedef struct packed {
		logic       status;
		logic [5:0] substitutions;
		logic       above;
		logic [15:0] count;
	} reply_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [23:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [15:0] cfg_data = '0;

	phone_confusion_alignment u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Predictor state.
	logic [15:0] thr_model;
	logic [5:0]  ref_seq [SEQ_MAX];
	logic [5:0]  obs_seq [SEQ_MAX];
	int          ref_len, obs_len;
	int          conf_tab [PHONES*PHONES];

	cmd_item_t   pending_items [$];
	reply_item_t expected_replies [$];
	int  send_idle_pct = 21;
	int  recv_idle_pct = 60;
	int  errors = 0;
	longint cycles = 0;

	function automatic void add_item(cmd_item_t it);
		pending_items.insert(pending_items.size(), it);
	endfunction

	function automatic int align_pair();
		int cost [EDGE*EDGE];
		logic [1:0] tr [EDGE*EDGE];
		logic [1:0] pcode [2*SEQ_MAX];
		int pri [2*SEQ_MAX];
		int poi [2*SEQ_MAX];
		int n, m, i, j, c, up, lf, dg, plen, subs, r, o;
		logic [1:0] later, earlier;
		n = ref_len; m = obs_len; plen = 0; subs = 0;
		for (i = 0; i <= n; i++) begin
			cost[i*EDGE] = i; tr[i*EDGE] = pca_pkg::TR_DEL;
		end
		for (j = 0; j <= m; j++) begin
			cost[j] = j; tr[j] = pca_pkg::TR_INS;
		end
		for (i = 1; i <= n; i++)
			for (j = 1; j <= m; j++) begin
				up = cost[(i-1)*EDGE+j];
				lf = cost[i*EDGE+j-1];
				dg = cost[(i-1)*EDGE+j-1];
				c = i*EDGE + j;
				if (ref_seq[i-1] == obs_seq[j-1]) begin
					cost[c] = dg; tr[c] = pca_pkg::TR_MAT;
				end else if (up < lf && up < dg) begin
					cost[c] = up + 1; tr[c] = pca_pkg::TR_DEL;
				end else if (lf < up && lf < dg) begin
					cost[c] = lf + 1; tr[c] = pca_pkg::TR_INS;
				end else begin
					cost[c] = dg + 1; tr[c] = pca_pkg::TR_SUB;
				end
			end
		i = n; j = m;
		while (i != 0 && j != 0 && plen < 2*SEQ_MAX) begin
			pcode[plen] = tr[i*EDGE+j];
			pri[plen] = i - 1; poi[plen] = j - 1;
			if (pcode[plen] == pca_pkg::TR_DEL) i--;
			else if (pcode[plen] == pca_pkg::TR_INS) j--;
			else begin
				i--; j--;
			end
			plen++;
		end
		// Path ends count as match neighbors.
		for (int k = 0; k < plen; k++) begin
			later = (k == 0) ? pca_pkg::TR_MAT : pcode[k-1];
			earlier = (k + 1 == plen) ? pca_pkg::TR_MAT : pcode[k+1];
			if (later == pca_pkg::TR_MAT && pcode[k] == pca_pkg::TR_SUB &&
					earlier == pca_pkg::TR_MAT) begin
				r = ref_seq[pri[k]]; o = obs_seq[poi[k]];
				if (subs < 63) subs++;
				if (conf_tab[r*PHONES+o] < 65535) conf_tab[r*PHONES+o]++;
			end
		end
		ref_len = 0; obs_len = 0;
		return subs;
	endfunction

	function automatic reply_item_t predict_reply(cmd_item_t it);
		reply_item_t rp;
		int v;
		rp = '0;
		case (it.action)
			pca_pkg::ACT_PUSH_REF: begin
				if (ref_len >= SEQ_MAX) rp.status = 1'b1;
				else begin
					ref_seq[ref_len] = it.phone; ref_len++;
				end
			end
			pca_pkg::ACT_PUSH_OBS: begin
				if (obs_len >= SEQ_MAX) rp.status = 1'b1;
				else begin
					obs_seq[obs_len] = it.phone; obs_len++;
				end
			end
			pca_pkg::ACT_ALIGN: rp.substitutions = 6'(align_pair());
			default: begin
				v = conf_tab[it.row*PHONES+it.col];
				rp.count = 16'(v);
				rp.above = (v > thr_model);
			end
		endcase
		return rp;
	endfunction

	function automatic cmd_item_t mk(logic [1:0] a, int p, int r, int c);
		cmd_item_t it;
		it.action = a; it.phone = 6'(p); it.row = 6'(r); it.col = 6'(c);
		return it;
	endfunction

	// Driver: prediction happens at acceptance, in order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_replies.insert(expected_replies.size(),
					predict_reply(cmd_item_t'(s_tdata[19:0])));
				void'(pending_items.pop_front());
			end
			if (pending_items.size() != 0) begin
				if (s_tvalid && !s_tready)
					s_tvalid <= 1'b1;
				else if ($urandom_range(99) < send_idle_pct) begin
					s_tvalid <= 1'b0;
				end else begin
					s_tvalid <= 1'b1;
					s_tdata <= {4'b0, pending_items[0]};
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor.
	always @(posedge clk) begin
		reply_item_t got, exp_r;
		cycles++;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = reply_item_t'(m_tdata);
				if (expected_replies.size() == 0) begin
					$error("unexpected result %h", m_tdata);
					errors++;
				end else begin
					exp_r = expected_replies.pop_front();
					if (got.count !== exp_r.count) begin
						$error("count exp %0d got %0d", exp_r.count, got.count); errors++;
					end
					if (got.above !== exp_r.above) begin
						$error("above_threshold exp %0d got %0d", exp_r.above, got.above);
						errors++;
					end
					if (got.substitutions !== exp_r.substitutions) begin
						$error("substitutions exp %0d got %0d", exp_r.substitutions,
							got.substitutions);
						errors++;
					end
					if (got.status !== exp_r.status) begin
						$error("status exp %0d got %0d", exp_r.status, got.status); errors++;
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_items.size() != 0 || s_tvalid || expected_replies.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_threshold(logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		thr_model = v;
		cfg_valid <= 1'b0;
	endtask

	// A pair that is mostly equal with a few substitutions, so that
	// isolated confusions are counted often.
	task automatic queue_pair(int len_r, int len_o, int noise);
		int p;
		for (int k = 0; k < len_r; k++) begin
			p = $urandom_range(63);
			add_item(mk(pca_pkg::ACT_PUSH_REF, p, 0, 0));
			if (k < len_o)
				add_item(mk(pca_pkg::ACT_PUSH_OBS,
					($urandom_range(99) < noise) ? $urandom_range(63) : p, 0, 0));
		end
		for (int k = len_r; k < len_o; k++)
			add_item(mk(pca_pkg::ACT_PUSH_OBS, $urandom_range(63), 0, 0));
		add_item(mk(pca_pkg::ACT_ALIGN, $urandom_range(63), 0, 0));
	endtask

	task automatic queue_random(int total);
		int n;
		n = 0;
		while (n < total) begin
			if ($urandom_range(9) < 7) begin
				queue_pair($urandom_range(1, 8), $urandom_range(1, 8), 25);
				n += 10;
			end else if ($urandom_range(1) == 0) begin
				add_item(mk(pca_pkg::ACT_READ, 0, $urandom_range(63),
					$urandom_range(63)));
				n++;
			end else begin
				add_item(mk(2'($urandom_range(3)), $urandom_range(63),
					$urandom_range(63), $urandom_range(63)));
				n++;
			end
			// Extra reads of random cells.
			if ($urandom_range(3) == 0) begin
				add_item(mk(pca_pkg::ACT_READ, 0, $urandom_range(63),
					$urandom_range(63)));
				n++;
			end
		end
	endtask

	initial begin
		thr_model = pca_pkg::THRESHOLD_RESET;
		ref_len = 0; obs_len = 0;
		foreach (conf_tab[k]) conf_tab[k] = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty aligns, one isolated substitution repeated until
		// the count passes the threshold, full sequences, extreme reads.
		add_item(mk(pca_pkg::ACT_ALIGN, 0, 0, 0));
		add_item(mk(pca_pkg::ACT_PUSH_REF, 63, 0, 0));
		add_item(mk(pca_pkg::ACT_ALIGN, 0, 0, 0));
		for (int r = 0; r < 12; r++) begin
			add_item(mk(pca_pkg::ACT_PUSH_REF, 63, 0, 0));
			add_item(mk(pca_pkg::ACT_PUSH_OBS, 0, 0, 0));
			add_item(mk(pca_pkg::ACT_ALIGN, 0, 0, 0));
		end
		add_item(mk(pca_pkg::ACT_READ, 0, 63, 0));
		add_item(mk(pca_pkg::ACT_READ, 0, 0, 63));
		wait_drained();
		write_threshold(16'd11);
		add_item(mk(pca_pkg::ACT_READ, 0, 63, 0));
		for (int k = 0; k < 33; k++) add_item(mk(pca_pkg::ACT_PUSH_REF, k, 0, 0));
		for (int k = 0; k < 33; k++)
			add_item(mk(pca_pkg::ACT_PUSH_OBS, (k == 5) ? 42 : k, 0, 0));
		add_item(mk(pca_pkg::ACT_ALIGN, 0, 0, 0));
		add_item(mk(pca_pkg::ACT_READ, 0, 5, 42));
		wait_drained();

		send_idle_pct = 21; recv_idle_pct = 60;
		write_threshold(16'hFFFF);
		queue_random(145);
		wait_drained();

		send_idle_pct = 60; recv_idle_pct = 21;
		write_threshold(16'd0);
		queue_random(145);
		wait_drained();

		send_idle_pct = 0; recv_idle_pct = 0;
		write_threshold(16'($urandom_range(1, 3)));
		queue_random(145);
		wait_drained();
		repeat (50) @(posedge clk);

		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

/* filelist.f */
hw/rtl/pca_pkg.sv
hw/rtl/pca_ram.sv
hw/rtl/pca_datapath.sv
hw/rtl/pca_ctrl.sv
hw/rtl/phone_confusion_alignment.sv
tb/sv/tb_phone_confusion_alignment.sv
